[rtl/core/aptrf_pkg.sv]
// Package: shared types and constants for the aging peer table forwarder.
`default_nettype none
package aptrf_pkg;

  localparam int unsigned PeerEntries = 64;
  localparam int unsigned RoomBytes   = 16;
  localparam int unsigned SlotW       = $clog2(PeerEntries);
  localparam int unsigned CntW        = $clog2(PeerEntries + 1);
  localparam int unsigned TimeW       = 48;
  localparam int unsigned QDepth      = 2;

  localparam logic [31:0] TimeoutReset = 32'd30000;
  localparam logic [31:0] AllOnesAddr  = 32'hFFFF_FFFF;
  localparam logic [1:0]  ModeData     = 2'd1;
  localparam logic [0:0]  RegTimeout   = 1'b0;
  localparam logic        KindLearn    = 1'b0;
  localparam logic        KindDeliver  = 1'b1;

  function automatic logic [63:0] byte_mask(int bytes);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < bytes) m[8*i +: 8] = 8'hFF;
    end
    return m;
  endfunction

  localparam logic [63:0] RoomLowMask  = byte_mask(RoomBytes);
  localparam logic [63:0] RoomHighMask = byte_mask(RoomBytes - 8);

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] now_ms;
    logic [63:0] room_low;
    logic [63:0] room_high;
    logic [31:0] source_address;
    logic [31:0] target_address;
    logic        broadcast_flag;
    logic [31:0] endpoint_address;
    logic [15:0] endpoint_port;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  slot;
    logic [31:0] dest_address;
    logic [15:0] dest_port;
    logic        last;
  } rsp_t;

  // classified job handed from front to back
  typedef struct packed {
    logic        fwd;
    logic        bcast;
    logic [47:0] now_ms;
    logic [63:0] room_low;
    logic [63:0] room_high;
    logic [31:0] src;
    logic [31:0] tgt;
    logic [31:0] eaddr;
    logic [15:0] eport;
  } job_t;

  typedef enum logic [6:0] {
    StIdle  = 7'b0000001,
    StExp   = 7'b0000010,
    StScan  = 7'b0000100,
    StLearn = 7'b0001000,
    StRep   = 7'b0010000,
    StFwd   = 7'b0100000,
    StFwdCk = 7'b1000000
  } state_e;

endpackage
`default_nettype wire

[rtl/core/aptrf_front.sv]
// Front end: accept headers, classify them, and queue jobs for the table engine.
`default_nettype none
module aptrf_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire aptrf_pkg::req_t in_data_i,
  output logic                 job_valid_o,
  input  wire logic            job_ready_i,
  output aptrf_pkg::job_t      job_o
);
  import aptrf_pkg::*;

  job_t            q_mem [QDepth];
  logic [0:0]      wr_q, rd_q;
  logic [1:0]      cnt_q;
  job_t            job_c;
  logic            push, pop;

  always_comb begin
    job_c.fwd       = (in_data_i.mode == ModeData);
    job_c.bcast     = in_data_i.broadcast_flag | (in_data_i.target_address == AllOnesAddr);
    job_c.now_ms    = in_data_i.now_ms;
    job_c.room_low  = in_data_i.room_low & RoomLowMask;
    job_c.room_high = in_data_i.room_high & RoomHighMask;
    job_c.src       = in_data_i.source_address;
    job_c.tgt       = in_data_i.target_address;
    job_c.eaddr     = in_data_i.endpoint_address;
    job_c.eport     = in_data_i.endpoint_port;
  end

  assign in_ready_o  = (cnt_q != 2'(QDepth));
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_mem[rd_q];
  assign push        = in_valid_i & in_ready_o;
  assign pop         = job_valid_o & job_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= job_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(QDepth)) else $error("queue overflow");
  a_push_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1) else $error("push lost");
  a_pop_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !push |=> cnt_q == $past(cnt_q) - 2'd1) else $error("pop lost");
`endif
endmodule
`default_nettype wire

[rtl/core/aptrf_back.sv]
// Back end: table memory, aging, learning and forwarding sequencer.
`default_nettype none
module aptrf_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [31:0]     timeout_i,
  input  wire logic            job_valid_i,
  output logic                 job_ready_o,
  input  wire aptrf_pkg::job_t job_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output aptrf_pkg::rsp_t      out_data_o
);
  import aptrf_pkg::*;

  typedef struct packed {
    logic [63:0] rlow;
    logic [63:0] rhigh;
    logic [31:0] laddr;
    logic [31:0] eaddr;
    logic [15:0] eport;
    logic [47:0] seen;
  } ent_t;

  ent_t                   mem [PeerEntries];
  ent_t                   rd_q;
  logic [PeerEntries-1:0] val_q;
  state_e                 st_q;
  job_t                   job_q;
  logic [CntW-1:0]        idx_q;
  logic [SlotW-1:0]       rdx_q;   // index of entry in rd_q
  logic                   match_f_q, free_f_q, old_f_q;
  logic [SlotW-1:0]       match_q, free_q, old_q, slot_q;
  logic [47:0]            old_age_q;
  rsp_t                   out_q;
  rsp_t                   pd_q;    // newest result, held until the next one is known
  logic                   ov_q;
  logic                   have_q;  // rd_q holds a fresh read

  logic [47:0] age;
  logic        key_room, hit_ok;
  logic        wr_en;
  ent_t        wr_e;
  logic [SlotW-1:0] wr_a;
  logic [SlotW-1:0] idx_s;
  logic        fin, dlv, rel;

  assign idx_s    = idx_q[SlotW-1:0];
  assign age      = job_q.now_ms - rd_q.seen;
  assign key_room = (rd_q.rlow == job_q.room_low) && (rd_q.rhigh == job_q.room_high);
  assign hit_ok   = job_q.bcast ? (rd_q.laddr != job_q.src) : (rd_q.laddr == job_q.tgt);
  assign job_ready_o = (st_q == StIdle);
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  assign fin = (st_q == StFwd) && (!job_q.fwd || idx_q == CntW'(PeerEntries));
  assign dlv = (st_q == StFwdCk) && val_q[rdx_q] && key_room && hit_ok;
  assign rel = (fin || dlv) && (!ov_q || out_ready_i);

  // learn write: key, endpoint and time all come from the job
  always_comb begin
    wr_en = (st_q == StLearn);
    wr_a  = slot_q;
    wr_e.rlow  = job_q.room_low;
    wr_e.rhigh = job_q.room_high;
    wr_e.laddr = job_q.src;
    wr_e.eaddr = job_q.eaddr;
    wr_e.eport = job_q.eport;
    wr_e.seen  = job_q.now_ms;
  end

  // single read port, registered
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_a] <= wr_e;
    rd_q  <= mem[(st_q == StScan && idx_q == CntW'(PeerEntries)) ? slot_q : idx_s];
    rdx_q <= idx_s;
    if (st_q == StIdle && job_valid_i) job_q <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= StIdle;
      val_q     <= '0;
      idx_q     <= '0;
      ov_q      <= 1'b0;
      have_q    <= 1'b0;
      match_f_q <= 1'b0;
      free_f_q  <= 1'b0;
      old_f_q   <= 1'b0;
      match_q   <= '0;
      free_q    <= '0;
      old_q     <= '0;
      slot_q    <= '0;
      old_age_q <= '0;
      out_q     <= '0;
      pd_q      <= '0;
    end else begin
      if (rel) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
      // release the held result; the final one carries last
      if (rel) out_q <= fin ? rsp_t'({pd_q[$bits(rsp_t)-1:1], 1'b1}) : pd_q;
      unique case (st_q)
        StIdle: begin
          if (job_valid_i) begin
            st_q      <= StExp;
            idx_q     <= '0;
            have_q    <= 1'b0;
            match_f_q <= 1'b0;
            free_f_q  <= 1'b0;
            old_f_q   <= 1'b0;
          end
        end
        // each pass (StExp, then StScan): expire, then match, free and oldest on survivors
        StExp, StScan: begin
          if (have_q) begin
            if (val_q[rdx_q] && age > 48'(timeout_i)) begin
              val_q[rdx_q] <= 1'b0;
              if (!free_f_q) begin
                free_f_q <= 1'b1;
                free_q   <= rdx_q;
              end
            end else if (val_q[rdx_q]) begin
              if (!match_f_q && rd_q.laddr == job_q.src && key_room) begin
                match_f_q <= 1'b1;
                match_q   <= rdx_q;
              end
              if (!old_f_q || age > old_age_q) begin
                old_f_q   <= 1'b1;
                old_q     <= rdx_q;
                old_age_q <= age;
              end
            end else if (!free_f_q) begin
              free_f_q <= 1'b1;
              free_q   <= rdx_q;
            end
          end
          if (idx_q == CntW'(PeerEntries)) begin
            have_q <= 1'b0;
            if (st_q == StExp) begin
              // last entry result lands this cycle; choose next
              st_q <= StScan;
            end else begin
              st_q <= StLearn;
            end
          end else begin
            have_q <= 1'b1;
            idx_q  <= idx_q + 1'b1;
          end
          if (st_q == StScan) begin
            slot_q <= match_f_q ? match_q : (free_f_q ? free_q : old_q);
          end
        end
        StLearn: begin
          val_q[slot_q] <= 1'b1;
          st_q <= StRep;
        end
        StRep: begin
          pd_q   <= '{kind: KindLearn, slot: 6'(slot_q), dest_address: job_q.eaddr,
                      dest_port: job_q.eport, last: 1'b0};
          idx_q  <= '0;
          have_q <= 1'b0;
          st_q   <= StFwd;
        end
        // read one entry, then check it and emit
        StFwd: begin
          if (fin) begin
            if (rel) st_q <= StIdle;
          end else begin
            st_q <= StFwdCk;
          end
        end
        StFwdCk: begin
          if (dlv) begin
            if (rel) begin
              pd_q  <= '{kind: KindDeliver, slot: 6'(rdx_q), dest_address: rd_q.eaddr,
                         dest_port: rd_q.eport, last: 1'b0};
              idx_q <= idx_q + 1'b1;
              st_q  <= StFwd;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
            st_q  <= StFwd;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != StIdle |-> !job_ready_o) else $error("ready while busy");
  a_learn_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == StLearn |=> val_q[$past(slot_q)]) else $error("learned slot not valid");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i && st_q == StFwdCk |=> ov_q) else $error("result dropped");
`endif
endmodule
`default_nettype wire

[rtl/core/aptrf_cfg.sv]
// APB configuration register file holding the entry timeout.
`default_nettype none
module aptrf_cfg (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [31:0]      timeout_o
);
  import aptrf_pkg::*;

  logic [31:0] timeout_q;
  logic        hit;

  assign hit       = (paddr == {RegTimeout, 1'b0});
  assign pready    = 1'b1;
  assign prdata    = hit ? timeout_q : 32'd0;
  assign timeout_o = timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (psel && penable && pwrite && hit) begin
      timeout_q <= pwdata;
    end
  end
endmodule
`default_nettype wire

[rtl/core/aptrf_out.sv]
// Output register for the result stream; the last flag passes through unchanged.
`default_nettype none
module aptrf_out (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire aptrf_pkg::rsp_t in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output aptrf_pkg::rsp_t      out_data_o
);
  import aptrf_pkg::*;

  rsp_t d_q;
  logic v_q;

  assign in_ready_o  = !v_q || out_ready_i;
  assign out_valid_o = v_q;
  assign out_data_o  = d_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) d_q <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= 1'b0;
    else if (in_ready_o) v_q <= in_valid_i;
  end
endmodule
`default_nettype wire

[rtl/core/aging_peer_table_relay_forwarder.sv]
// Top level: aging peer table relay forwarder.
// The learned slot report is held until the next result is known: for data headers until the
//   first delivery is found or the forward scan ends, for other headers until the scan ends.
// The table engine takes a new header only when idle; it scans the single-port table in
//   expire and match passes (StExp, StScan), then a forward pass that reads and checks each entry.
// Reset: asynchronous active low; clears entry valid bits, queue and timeout to 30000.
// The two-entry job queue lets headers arrive while the table engine is busy.
`default_nettype none
module aging_peer_table_relay_forwarder (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire aptrf_pkg::req_t in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output aptrf_pkg::rsp_t      out_data_o,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [1:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import aptrf_pkg::*;

  job_t        job;
  logic        job_valid, job_ready;
  logic [31:0] timeout;
  rsp_t        b_data;
  logic        b_valid, b_ready;

  aptrf_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .timeout_o(timeout)
  );

  // accept and classify requests
  aptrf_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  // table engine
  aptrf_back u_back (
    .clk_i, .rst_ni, .timeout_i(timeout),
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_data_o(b_data)
  );

  // hold results until the consumer takes them
  aptrf_out u_out (
    .clk_i, .rst_ni, .in_valid_i(b_valid), .in_ready_o(b_ready), .in_data_i(b_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );
endmodule
`default_nettype wire

[dv/aging_peer_table_relay_forwarder_test.sv]
// Testbench for the aging peer table relay forwarder: directed table plus random traffic.
`default_nettype none
module aging_peer_table_relay_forwarder_test;
  timeunit 1ns;
  timeprecision 1ps;
  import aptrf_pkg::*;

  localparam logic [1:0]  TimeoutAddr = 2'(4 * RegTimeout);
  localparam logic [1:0]  ModeRegister = 2'd0;
  localparam logic [1:0]  ModeOther    = 2'd2;
  localparam logic [1:0]  ModeSpare    = 2'd3;
  localparam logic [47:0] TimeMax      = 48'hFFFF_FFFF_FFFF;
  localparam int          IdleLimit    = 20000;
  localparam int          DrainCycles  = 3 * PeerEntries + 20;

  // One row of the directed table; rows with a typed answer expect a single result.
  typedef struct {
    req_t req;
    bit   typed;
    rsp_t rsp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  aging_peer_table_relay_forwarder i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the peer table and the timeout register.
  logic        peer_valid [PeerEntries];
  logic [63:0] peer_room_low [PeerEntries];
  logic [63:0] peer_room_high [PeerEntries];
  logic [31:0] peer_logical [PeerEntries];
  logic [31:0] peer_ep_addr [PeerEntries];
  logic [15:0] peer_ep_port [PeerEntries];
  logic [47:0] peer_seen [PeerEntries];
  logic [31:0] timeout_shadow = TimeoutReset;

  rsp_t due_rsp_q[$];    // results still owed by the block, oldest first
  bit   typed_row_q[$];  // per request in send order: typed answer follows
  rsp_t typed_rsp_q[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   hold_off = 0;    // receiver long stall, counted down per cycle
  int   out_stall_pct = 0;
  int   in_gap_pct = 0;

  task automatic report(input string what);
    $display("[%0t] %s", $realtime, what);
    mismatches++;
  endtask

  // Expire stale peers, learn the sender, then list the forwarding targets.
  function automatic void learn_and_forward(input req_t r, ref rsp_t res[$]);
    logic [63:0] rl, rh;
    logic [47:0] age, oldest_age;
    int slot, free_slot, oldest;
    bit bcast;
    rsp_t e;
    rl = r.room_low & RoomLowMask;
    rh = r.room_high & RoomHighMask;
    slot = -1;
    free_slot = -1;
    oldest = -1;
    oldest_age = '0;
    for (int i = 0; i < PeerEntries; i++) begin
      age = r.now_ms - peer_seen[i];
      if (peer_valid[i] && age > {16'b0, timeout_shadow}) peer_valid[i] = 1'b0;
    end
    for (int i = 0; i < PeerEntries; i++) begin
      if (peer_valid[i]) begin
        age = r.now_ms - peer_seen[i];
        if (slot < 0 && peer_logical[i] == r.source_address &&
            peer_room_low[i] == rl && peer_room_high[i] == rh) slot = i;
        if (oldest < 0 || age > oldest_age) begin
          oldest = i;
          oldest_age = age;
        end
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (slot < 0) begin
      slot = (free_slot >= 0) ? free_slot : oldest;
      peer_valid[slot] = 1'b1;
      peer_room_low[slot] = rl;
      peer_room_high[slot] = rh;
      peer_logical[slot] = r.source_address;
    end
    peer_ep_addr[slot] = r.endpoint_address;
    peer_ep_port[slot] = r.endpoint_port;
    peer_seen[slot] = r.now_ms;
    e.kind = KindLearn;
    e.slot = slot[5:0];
    e.dest_address = r.endpoint_address;
    e.dest_port = r.endpoint_port;
    e.last = 1'b0;
    res.push_back(e);
    if (r.mode == ModeData) begin
      bcast = r.broadcast_flag || r.target_address == AllOnesAddr;
      for (int i = 0; i < PeerEntries && res.size() < PeerEntries; i++) begin
        if (!peer_valid[i] || peer_room_low[i] != rl || peer_room_high[i] != rh) continue;
        if (bcast ? peer_logical[i] == r.source_address
                  : peer_logical[i] != r.target_address) continue;
        e.kind = KindDeliver;
        e.slot = i[5:0];
        e.dest_address = peer_ep_addr[i];
        e.dest_port = peer_ep_port[i];
        res.push_back(e);
      end
    end
    res[res.size() - 1].last = 1'b1;
  endfunction

  // Predict on every accepted request; check every accepted result.
  always @(posedge clk_i) begin
    rsp_t pred[$];
    rsp_t exp_rsp;
    bit typed;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (in_valid_i && in_ready_o) begin
        pred.delete();
        learn_and_forward(in_data_i, pred);
        typed = typed_row_q.pop_front();
        if (typed) due_rsp_q.push_back(typed_rsp_q.pop_front());
        else foreach (pred[k]) due_rsp_q.push_back(pred[k]);
      end
      if (out_valid_o && out_ready_i) begin
        if (due_rsp_q.size() == 0) begin
          report($sformatf("result with nothing expected: %p", out_data_o));
        end else begin
          exp_rsp = due_rsp_q.pop_front();
          if (out_data_o.kind !== exp_rsp.kind)
            report($sformatf("kind %0d, want %0d", out_data_o.kind, exp_rsp.kind));
          if (out_data_o.slot !== exp_rsp.slot)
            report($sformatf("slot %0d, want %0d", out_data_o.slot, exp_rsp.slot));
          if (out_data_o.dest_address !== exp_rsp.dest_address)
            report($sformatf("dest_address %h, want %h",
                             out_data_o.dest_address, exp_rsp.dest_address));
          if (out_data_o.dest_port !== exp_rsp.dest_port)
            report($sformatf("dest_port %h, want %h", out_data_o.dest_port, exp_rsp.dest_port));
          if (out_data_o.last !== exp_rsp.last)
            report($sformatf("last %0d, want %0d", out_data_o.last, exp_rsp.last));
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: random stalls, occasional long ones, and an explicit hold-off.
  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_ready_i <= 1'b0;
      hold_off--;
    end else if (out_stall_pct > 0 && $urandom_range(0, 199) == 0) begin
      out_ready_i <= 1'b0;
      hold_off = $urandom_range(20, 80);
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  function automatic req_t mk(input logic [1:0] mode, input logic [47:0] now_ms,
                              input logic [63:0] rl, input logic [63:0] rh,
                              input logic [31:0] src, input logic [31:0] tgt,
                              input logic bflag, input logic [31:0] ea,
                              input logic [15:0] ep);
    req_t r;
    r.mode = mode;
    r.now_ms = now_ms;
    r.room_low = rl;
    r.room_high = rh;
    r.source_address = src;
    r.target_address = tgt;
    r.broadcast_flag = bflag;
    r.endpoint_address = ea;
    r.endpoint_port = ep;
    return r;
  endfunction

  function automatic rsp_t learned(input int slot, input logic [31:0] ea, input logic [15:0] ep);
    rsp_t e;
    e.kind = KindLearn;
    e.slot = slot[5:0];
    e.dest_address = ea;
    e.dest_port = ep;
    e.last = 1'b1;
    return e;
  endfunction

  // Offer one request and hold it until accepted; valid stays up for the next one.
  task automatic send_request(input req_t r, input bit typed, input rsp_t rsp);
    int gap;
    if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    typed_row_q.push_back(typed);
    if (typed) typed_rsp_q.push_back(rsp);
    in_valid_i <= 1'b1;
    in_data_i <= r;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (due_rsp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // APB write of the timeout register, then read it back.
  task automatic set_timeout(input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= TimeoutAddr; pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    timeout_shadow = value;
    @(negedge clk_i);
    penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== value) report($sformatf("timeout reads %h, want %h", prdata, value));
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  // One random phase: mostly traffic from a few rooms and a pool of senders.
  task automatic random_phase(input int items, input int n_senders, input logic [47:0] start);
    logic [63:0] room_lo [3];
    logic [63:0] room_hi [3];
    logic [31:0] sender [80];
    logic [47:0] now_ms;
    logic [31:0] step_cap;
    req_t r;
    int k;
    for (int i = 0; i < 3; i++) begin
      room_lo[i] = {$urandom, $urandom};
      room_hi[i] = {$urandom, $urandom};
    end
    foreach (sender[i]) sender[i] = $urandom;
    now_ms = start;
    step_cap = (timeout_shadow > 32'd80000) ? 32'd10000 : timeout_shadow / 8;
    for (int n = 0; n < items; n++) begin
      if ($urandom_range(0, 99) < 12) begin
        // noise: every field random
        r = mk(2'($urandom), {16'($urandom), 32'($urandom)}, {$urandom, $urandom},
               {$urandom, $urandom}, $urandom, $urandom, 1'($urandom), $urandom,
               16'($urandom));
      end else begin
        if (timeout_shadow == 0) now_ms += ($urandom_range(0, 3) == 0);
        else if ($urandom_range(0, 24) == 0) now_ms += timeout_shadow + 48'd1;
        else now_ms += $urandom_range(0, step_cap);
        k = $urandom_range(0, 2);
        r = mk(($urandom_range(0, 9) < 7) ? ModeData : 2'($urandom_range(0, 3)), now_ms,
               room_lo[k], room_hi[k], sender[$urandom_range(0, n_senders - 1)],
               $urandom, ($urandom_range(0, 9) == 0), $urandom, 16'($urandom));
        case ($urandom_range(0, 9))
          0, 1, 2:    r.target_address = AllOnesAddr;
          3, 4, 5, 6: r.target_address = sender[$urandom_range(0, n_senders - 1)];
          default: ;
        endcase
      end
      send_request(r, 1'b0, '0);
    end
  endtask

  stim_row_t rows[12];
  logic [63:0] room_a;

  initial begin
    room_a = 64'h0123_4567_89AB_CDEF;
    rows[0]  = '{mk(ModeRegister, 48'd1000, room_a, '0, 32'd1, 32'd0, 1'b0, 32'hA, 16'd10),
                 1'b1, learned(0, 32'hA, 16'd10)};
    rows[1]  = '{mk(ModeRegister, 48'd1000, room_a, '0, 32'd2, 32'd0, 1'b0, 32'hB, 16'd11),
                 1'b1, learned(1, 32'hB, 16'd11)};
    // broadcast by flag, by all-ones target, then unicast
    rows[2]  = '{mk(ModeData, 48'd1100, room_a, '0, 32'd1, 32'd5, 1'b1, 32'hA, 16'd10),
                 1'b0, '0};
    rows[3]  = '{mk(ModeData, 48'd1100, room_a, '0, 32'd2, AllOnesAddr, 1'b0, 32'hB, 16'd11),
                 1'b0, '0};
    rows[4]  = '{mk(ModeData, 48'd1200, room_a, '0, 32'd1, 32'd2, 1'b0, 32'hA, 16'd10),
                 1'b0, '0};
    // other packet types learn and do not forward
    rows[5]  = '{mk(ModeOther, 48'd1200, room_a, '0, 32'd3, AllOnesAddr, 1'b1, 32'hC, 16'd12),
                 1'b1, learned(2, 32'hC, 16'd12)};
    rows[6]  = '{mk(ModeSpare, 48'd1200, room_a, '0, 32'd4, AllOnesAddr, 1'b1, 32'hD, 16'd13),
                 1'b1, learned(3, 32'hD, 16'd13)};
    // unicast to nobody: refresh only
    rows[7]  = '{mk(ModeData, 48'd1300, room_a, '0, 32'd1, 32'd99, 1'b0, 32'hA, 16'd10),
                 1'b1, learned(0, 32'hA, 16'd10)};
    // same logical address in another room is a new peer
    rows[8]  = '{mk(ModeRegister, 48'd1300, '0, room_a, 32'd1, 32'd0, 1'b0, 32'hE, 16'd14),
                 1'b1, learned(4, 32'hE, 16'd14)};
    // time jumps to its maximum: everything expires, no peers left
    rows[9]  = '{mk(ModeData, TimeMax, '1, '1, '1, '0, 1'b1, '1, '1),
                 1'b1, learned(0, '1, '1)};
    // time wraps to zero: age of one, entry survives
    rows[10] = '{mk(ModeRegister, '0, '0, '0, '0, '0, 1'b0, '0, '0), 1'b0, '0};
    rows[11] = '{mk(ModeData, '0, '1, '1, 32'd7, AllOnesAddr, 1'b0, 32'h5, 16'd5), 1'b0, '0};

    foreach (peer_valid[i]) peer_valid[i] = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].rsp);
    drain();

    in_gap_pct = 30;
    out_stall_pct = 30;
    random_phase(70, 40, 48'd5000);
    drain();

    // fill the table so eviction of the oldest peer happens
    set_timeout(32'hFFFF_FFFF);
    random_phase(110, 80, TimeMax - 48'd300000);
    drain();

    // block fills up while the receiver holds off
    set_timeout(32'd0);
    in_gap_pct = 0;
    hold_off = 3000;
    random_phase(60, 20, 48'd77);
    drain();

    set_timeout(32'd1);
    out_stall_pct = 0;
    random_phase(70, 30, 48'd123456);
    drain();

    set_timeout(32'd500);
    in_gap_pct = 30;
    out_stall_pct = 50;
    random_phase(70, 30, 48'd9000);
    drain();

    set_timeout($urandom_range(1000, 100000));
    out_stall_pct = 20;
    random_phase(70, 60, {16'($urandom), 32'($urandom)});
    drain();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
